// File: src/wprs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wprs_pkg;

    // Frame geometry and counter sizing
    localparam int MAX_WIDTH    = 4096;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int CFG_COL_BITS = 13;
    localparam int CMP_BITS     = (COL_BITS + 1 > CFG_COL_BITS) ? COL_BITS + 1 : CFG_COL_BITS;
    localparam int COUNT_BITS   = 24;
    localparam int OUT_COUNT_BITS = 24;
    localparam int SPEED_BITS   = 14;
    localparam int CMD_BITS     = 15;

    // Register map (index = paddr / 4)
    localparam int ADDR_BITS = 5;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [2:0] REG_LEFT_BOUND  = 3'd1;
    localparam logic [2:0] REG_RIGHT_BOUND = 3'd2;
    localparam logic [2:0] REG_WHITE_LEVEL = 3'd3;
    localparam logic [2:0] REG_DRIVE_SPEED = 3'd4;
    localparam logic [2:0] REG_TURN_SPEED  = 3'd5;

    // Band codes
    localparam logic [1:0] BAND_LEFT   = 2'd0;
    localparam logic [1:0] BAND_MIDDLE = 2'd1;
    localparam logic [1:0] BAND_RIGHT  = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_LEFT    = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_RIGHT   = 2'd2;
    localparam logic [1:0] DIR_STOP    = 2'd3;

    // Queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [CFG_COL_BITS-1:0] image_width;
        logic [CFG_COL_BITS-1:0] left_bound;
        logic [CFG_COL_BITS-1:0] right_bound;
        logic [7:0]              white_level;
        logic [SPEED_BITS-1:0]   drive_speed;
        logic [SPEED_BITS-1:0]   turn_speed;
    } cfg_t;

    // Classified pixel passed from front to back
    typedef struct packed {
        logic       white;
        logic [1:0] band;
        logic       last;
    } item_t;

endpackage

`default_nettype wire

// File: src/wprs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wprs_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

interface wprs_result_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               direction;
    logic signed [14:0]       linear_speed;
    logic signed [14:0]       angular_speed;
    logic [23:0]              left_count;
    logic [23:0]              middle_count;
    logic [23:0]              right_count;

    modport source (output valid, direction, linear_speed, angular_speed,
                    left_count, middle_count, right_count, input ready);
    modport sink   (input valid, direction, linear_speed, angular_speed,
                    left_count, middle_count, right_count, output ready);
endinterface

`default_nettype wire

// File: src/wprs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wprs_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    wprs_pixel_if.sink            pix,
    input  wire wprs_pkg::cfg_t   cfg,
    output wprs_pkg::item_t       item,
    output logic                  item_valid,
    input  wire logic             item_ready
);

    logic [wprs_pkg::COL_BITS-1:0] column_reg;
    logic [wprs_pkg::COL_BITS-1:0] column_next;
    logic [wprs_pkg::CMP_BITS-1:0] col_wide;
    logic [wprs_pkg::CMP_BITS-1:0] col_inc;
    logic                          accept;

    // Pass transfers straight through to the queue
    assign pix.ready  = item_ready;
    assign item_valid = pix.valid;
    assign accept     = pix.valid && item_ready;

    assign col_wide = wprs_pkg::CMP_BITS'(column_reg);
    assign col_inc  = col_wide + wprs_pkg::CMP_BITS'(1);

    // Classify the pixel by level and column band
    always_comb
    begin
        item.white = (pix.red == cfg.white_level) && (pix.green == cfg.white_level)
                     && (pix.blue == cfg.white_level);
        item.last  = pix.frame_end;
        if (col_wide < wprs_pkg::CMP_BITS'(cfg.left_bound))
        begin
            item.band = wprs_pkg::BAND_LEFT;
        end
        else if (col_wide < wprs_pkg::CMP_BITS'(cfg.right_bound))
        begin
            item.band = wprs_pkg::BAND_MIDDLE;
        end
        else
        begin
            item.band = wprs_pkg::BAND_RIGHT;
        end
    end

    // Advance the column, wrap at the row end, restart at frame end
    always_comb
    begin
        column_next = column_reg;
        if (accept)
        begin
            if (pix.frame_end
                || col_inc >= wprs_pkg::CMP_BITS'(cfg.image_width)
                || col_inc >= wprs_pkg::CMP_BITS'(wprs_pkg::MAX_WIDTH))
            begin
                column_next = '0;
            end
            else
            begin
                column_next = col_inc[wprs_pkg::COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
        end
        else
        begin
            column_reg <= column_next;
        end
    end

endmodule

`default_nettype wire

// File: src/wprs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wprs_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire wprs_pkg::item_t  wr_item,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    output wprs_pkg::item_t       rd_item,
    output logic                  rd_valid,
    input  wire logic             rd_ready
);

    wprs_pkg::item_t                  slot_reg [wprs_pkg::QUEUE_DEPTH];
    logic [wprs_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [wprs_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [wprs_pkg::QPTR_BITS:0]     fill_reg;
    logic [wprs_pkg::QPTR_BITS:0]     fill_next;
    logic                             push;
    logic                             pop;

    assign wr_ready = (fill_reg != (wprs_pkg::QPTR_BITS+1)'(wprs_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// File: src/wprs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wprs_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire wprs_pkg::item_t  item,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire wprs_pkg::cfg_t   cfg,
    wprs_result_if.source         res
);

    localparam logic [wprs_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [wprs_pkg::COUNT_BITS-1:0] count_reg  [3];
    logic [wprs_pkg::COUNT_BITS-1:0] count_next [3];
    logic [wprs_pkg::COUNT_BITS-1:0] count_inc  [3];
    logic [wprs_pkg::COUNT_BITS-1:0] snap_reg   [3];
    logic                            snap_valid_reg;
    logic                            out_valid_reg;
    logic [1:0]                      dir_reg;
    logic [1:0]                      pick;
    logic [wprs_pkg::COUNT_BITS-1:0] best_lm;
    logic [1:0]                      pick_lm;
    logic [wprs_pkg::CMD_BITS-1:0]   lin_reg;
    logic [wprs_pkg::CMD_BITS-1:0]   ang_reg;
    logic [wprs_pkg::CMD_BITS-1:0]   lin_val;
    logic [wprs_pkg::CMD_BITS-1:0]   ang_val;
    logic [wprs_pkg::CMD_BITS-1:0]   turn_wide;
    logic [wprs_pkg::COUNT_BITS-1:0] out_count_reg [3];
    logic                            out_free;
    logic                            snap_adv;
    logic                            pop;

    // Result stage drains into the output register
    assign out_free   = !out_valid_reg || res.ready;
    assign snap_adv   = snap_valid_reg && out_free;
    assign item_ready = !item.last || !snap_valid_reg || snap_adv;
    assign pop        = item_valid && item_ready;

    // Update the saturating band counts
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            count_inc[i] = count_reg[i];
            if (item.white && (item.band == 2'(i)) && (count_reg[i] != COUNT_MAX))
            begin
                count_inc[i] = count_reg[i] + 1'b1;
            end
            count_next[i] = count_reg[i];
            if (pop)
            begin
                count_next[i] = item.last ? '0 : count_inc[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // Capture the frame's final counts
    always_ff @(posedge clk)
    begin
        if (pop && item.last)
        begin
            for (int i = 0; i < 3; i++)
            begin
                snap_reg[i] <= count_inc[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (pop && item.last)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_adv)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    // Vote: strictly greatest band wins, earlier band on a tie, stop if none
    always_comb
    begin
        if (snap_reg[1] > snap_reg[0])
        begin
            pick_lm = wprs_pkg::DIR_FORWARD;
            best_lm = snap_reg[1];
        end
        else
        begin
            pick_lm = (snap_reg[0] != '0) ? wprs_pkg::DIR_LEFT : wprs_pkg::DIR_STOP;
            best_lm = snap_reg[0];
        end
        pick = (snap_reg[2] > best_lm) ? wprs_pkg::DIR_RIGHT : pick_lm;
    end

    // Map the direction to speed commands
    assign turn_wide = wprs_pkg::CMD_BITS'(cfg.turn_speed);
    always_comb
    begin
        lin_val = wprs_pkg::CMD_BITS'(cfg.drive_speed);
        ang_val = '0;
        unique case (pick)
            wprs_pkg::DIR_LEFT:
            begin
                ang_val = turn_wide;
            end
            wprs_pkg::DIR_FORWARD:
            begin
                ang_val = '0;
            end
            wprs_pkg::DIR_RIGHT:
            begin
                ang_val = '0 - turn_wide;
            end
            default:
            begin
                lin_val = '0;
            end
        endcase
    end

    // Hold the result until the transfer completes
    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            dir_reg <= pick;
            lin_reg <= lin_val;
            ang_reg <= ang_val;
            for (int i = 0; i < 3; i++)
            begin
                out_count_reg[i] <= snap_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (snap_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.direction     = dir_reg;
    assign res.linear_speed  = lin_reg;
    assign res.angular_speed = ang_reg;
    assign res.left_count    = wprs_pkg::OUT_COUNT_BITS'(out_count_reg[0]);
    assign res.middle_count  = wprs_pkg::OUT_COUNT_BITS'(out_count_reg[1]);
    assign res.right_count   = wprs_pkg::OUT_COUNT_BITS'(out_count_reg[2]);

endmodule

`default_nettype wire

// File: src/white_pixel_region_steering.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-band white pixel steering vote. Pixels stream in raster order on pix, one
// per clock at full rate; a pixel whose red, green and blue all equal white_level
// counts toward the left, middle or right band of its column (columns wrap at
// image_width, or at 4096 if less). On the pixel flagged frame_end, after counting
// it, one result is sent on res: the band with the strictly greatest count (earlier
// band on a tie, stop when no white pixel was seen), signed Q1.14 linear and
// angular speeds and the three saturating counts; counts and column then restart.
// A pixel is classified on entry, held in a four-entry queue and counted as it
// leaves; a frame's result goes through the snapshot and output registers to res.
// While a result waits on res, the next frame's result waits in a second stage;
// the queue stops draining only when a later frame's last pixel reaches its head
// with both stages full, and pixel intake stalls once the queue has filled behind
// that pixel. Registers sit at byte addresses 4*index on the APB port; the user
// must write them only while no frame is in flight; the block does not enforce it.
module white_pixel_region_steering (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    wprs_pixel_if.sink                          pix,
    wprs_result_if.source                       res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wprs_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    wprs_pkg::cfg_t  cfg_reg;
    wprs_pkg::item_t front_item;
    wprs_pkg::item_t back_item;
    logic            front_valid;
    logic            front_ready;
    logic            back_valid;
    logic            back_ready;
    logic            wr_en;
    logic [2:0]      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width <= 13'd640;
            cfg_reg.left_bound  <= 13'd213;
            cfg_reg.right_bound <= 13'd426;
            cfg_reg.white_level <= 8'd255;
            cfg_reg.drive_speed <= 14'd4915;
            cfg_reg.turn_speed  <= 14'd4915;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                wprs_pkg::REG_IMAGE_WIDTH: cfg_reg.image_width <= pwdata[12:0];
                wprs_pkg::REG_LEFT_BOUND:  cfg_reg.left_bound  <= pwdata[12:0];
                wprs_pkg::REG_RIGHT_BOUND: cfg_reg.right_bound <= pwdata[12:0];
                wprs_pkg::REG_WHITE_LEVEL: cfg_reg.white_level <= pwdata[7:0];
                wprs_pkg::REG_DRIVE_SPEED: cfg_reg.drive_speed <= pwdata[13:0];
                wprs_pkg::REG_TURN_SPEED:  cfg_reg.turn_speed  <= pwdata[13:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (reg_sel)
            wprs_pkg::REG_IMAGE_WIDTH: prdata = 32'(cfg_reg.image_width);
            wprs_pkg::REG_LEFT_BOUND:  prdata = 32'(cfg_reg.left_bound);
            wprs_pkg::REG_RIGHT_BOUND: prdata = 32'(cfg_reg.right_bound);
            wprs_pkg::REG_WHITE_LEVEL: prdata = 32'(cfg_reg.white_level);
            wprs_pkg::REG_DRIVE_SPEED: prdata = 32'(cfg_reg.drive_speed);
            wprs_pkg::REG_TURN_SPEED:  prdata = 32'(cfg_reg.turn_speed);
            default:                   prdata = '0;
        endcase
    end

    wprs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg_reg),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    wprs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (back_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    wprs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .cfg        (cfg_reg),
        .res        (res)
    );

endmodule

`default_nettype wire
